// ===== rtl/assert_macros.svh =====
// assertion macros for the address range coalescer
// no dependencies; included by the modules that check their own logic
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_PROP(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("%m: property failed");
`define ASSERT_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("%m: forbidden condition seen");
`else
`define ASSERT_PROP(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, expr)
`endif
`endif

// ===== rtl/arc_pkg.sv =====
// shared types and constants for the address range coalescer
// no dependencies; used by every module of the block
package arc_pkg;

    localparam int ADDR_BITS       = 48;
    localparam int DEF_NUM_VARS    = 4;
    localparam int DEF_MAX_REGIONS = 16;
    localparam int NUM_BASE_REGS   = 4;
    localparam int BASE_IDX_W      = $clog2(NUM_BASE_REGS);

    localparam int IDX_W      = 4;
    localparam int COUNT_W    = 32;
    localparam int ESIZE_W    = 16;
    localparam int BYTES_W    = 64;
    localparam int STATUS_W   = 3;
    localparam int NUM_VARS_W = 3;

    localparam int CFG_DATA_W = 64;
    localparam int CFG_ADDR_W = 6;
    localparam int REG_IDX_W  = 3;

    localparam logic [REG_IDX_W-1:0] REG_NUM_VARS = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_BASE_0   = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_BASE_3   = 3'd4;

    typedef enum logic [STATUS_W-1:0] {
        ST_MERGED     = 3'd0,
        ST_NEW        = 3'd1,
        ST_BAD_INDEX  = 3'd2,
        ST_ZERO_COUNT = 3'd3,
        ST_FULL       = 3'd4
    } t_status;

    typedef struct packed {
        logic [NUM_VARS_W-1:0]                     num_vars;
        logic [NUM_BASE_REGS-1:0][ADDR_BITS-1:0]   base;
    } t_cfg;

endpackage

// ===== rtl/arc_ram.sv =====
// generic single-port-write, single-port-read ram with registered read
// no dependencies beyond arc_pkg defaults
module arc_ram #(
    parameter int WIDTH = arc_pkg::ADDR_BITS,
    parameter int DEPTH = arc_pkg::DEF_MAX_REGIONS
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic                                   i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/arc_cfg.sv =====
// apb register file: variable count and per-variable base addresses
// depends on arc_pkg for register indexes and the t_cfg struct
module arc_cfg #(
    parameter int NUM_VARS = arc_pkg::DEF_NUM_VARS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [arc_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [arc_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic [arc_pkg::CFG_DATA_W-1:0]  prdata,
    output logic                            pready,
    output arc_pkg::t_cfg                   o_cfg
);

    arc_pkg::t_cfg                        r_cfg;
    logic                                 w_wr;
    logic [arc_pkg::REG_IDX_W-1:0]        w_reg;
    logic [arc_pkg::BASE_IDX_W-1:0]       w_bidx;

    assign w_wr   = psel && penable && pwrite;
    assign w_reg  = paddr[arc_pkg::CFG_ADDR_W-1:3];
    assign w_bidx = arc_pkg::BASE_IDX_W'(w_reg - arc_pkg::REG_BASE_0);
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (w_wr) begin
            unique case (w_reg) inside
                arc_pkg::REG_NUM_VARS: begin
                    r_cfg.num_vars <= pwdata[arc_pkg::NUM_VARS_W-1:0];
                end
                [arc_pkg::REG_BASE_0:arc_pkg::REG_BASE_3]: begin
                    if (int'(w_bidx) < NUM_VARS) begin
                        r_cfg.base[w_bidx] <= pwdata[arc_pkg::ADDR_BITS-1:0];
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (w_reg) inside
            arc_pkg::REG_NUM_VARS: begin
                prdata = arc_pkg::CFG_DATA_W'(r_cfg.num_vars);
            end
            [arc_pkg::REG_BASE_0:arc_pkg::REG_BASE_3]: begin
                prdata = arc_pkg::CFG_DATA_W'(r_cfg.base[w_bidx]);
            end
            default: begin
                prdata = '0;
            end
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

// ===== rtl/arc_core.sv =====
// region table engine: offset range, window compare against the two newest
// regions, merge or append, totals; depends on arc_pkg, arc_ram, assert_macros.svh
`include "assert_macros.svh"

module arc_core #(
    parameter int NUM_VARS    = arc_pkg::DEF_NUM_VARS,
    parameter int MAX_REGIONS = arc_pkg::DEF_MAX_REGIONS
) (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  arc_pkg::t_cfg                                 i_cfg,
    input  logic                                          i_valid,
    output logic                                          o_stall,
    input  logic [arc_pkg::IDX_W-1:0]                     i_var_index,
    input  logic [arc_pkg::ADDR_BITS-1:0]                 i_start_address,
    input  logic [arc_pkg::COUNT_W-1:0]                   i_elem_count,
    input  logic [arc_pkg::ESIZE_W-1:0]                   i_elem_bytes,
    output logic                                          o_valid,
    input  logic                                          i_stall,
    output logic [arc_pkg::STATUS_W-1:0]                  o_status,
    output logic [arc_pkg::ADDR_BITS-1:0]                 o_region_first,
    output logic [arc_pkg::ADDR_BITS-1:0]                 o_region_last,
    output logic [arc_pkg::BYTES_W-1:0]                   o_var_bytes,
    output logic [$clog2(MAX_REGIONS+1)-1:0]              o_var_regions,
    output logic [arc_pkg::BYTES_W-1:0]                   o_all_bytes,
    output logic [$clog2(NUM_VARS*MAX_REGIONS+1)-1:0]     o_all_regions
);

    localparam int A         = arc_pkg::ADDR_BITS;
    localparam int BW        = arc_pkg::BYTES_W;
    localparam int VAR_BITS  = (NUM_VARS > 1) ? $clog2(NUM_VARS) : 1;
    localparam int VAR_SLOTS = 2 ** VAR_BITS;
    localparam int SLOT_BITS = $clog2(MAX_REGIONS);
    localparam int CNT_BITS  = $clog2(MAX_REGIONS + 1);
    localparam int ALL_BITS  = $clog2(NUM_VARS * MAX_REGIONS + 1);
    localparam int MEM_ABITS = VAR_BITS + SLOT_BITS;
    localparam int MEM_DEPTH = 2 ** MEM_ABITS;
    localparam int ENTRY_W   = 2 * A;
    localparam int PROD_W    = arc_pkg::COUNT_W + arc_pkg::ESIZE_W;

    localparam logic [CNT_BITS-1:0]       MAX_CNT  = CNT_BITS'(MAX_REGIONS);
    localparam logic [arc_pkg::IDX_W:0]   NV_LIMIT = (arc_pkg::IDX_W + 1)'(NUM_VARS);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_LAST  = 5'b00010,
        S_MERGE = 5'b00100,
        S_SPAN  = 5'b01000,
        S_WRITE = 5'b10000
    } t_state;

    function automatic logic touch(input logic [A-1:0] a, input logic [A-1:0] b);
        return {1'b0, a} <= ({1'b0, b} + (A + 1)'(1));
    endfunction

    function automatic logic hit_test(input logic [A-1:0] f, input logic [A-1:0] l,
                                      input logic [A-1:0] rs, input logic [A-1:0] re);
        return ((f >= rs) && touch(f, re)) || ((l <= re) && touch(rs, l)) ||
               ((f <= rs) && (l >= re));
    endfunction

    function automatic logic [BW-1:0] span_size(input logic [A-1:0] f,
                                                input logic [A-1:0] l);
        logic [A-1:0] d;
        d = l - f;
        return BW'(d) + BW'(1);
    endfunction

    t_state                   r_state, n_state;

    logic [CNT_BITS-1:0]      r_count  [VAR_SLOTS];
    logic [BW-1:0]            r_vbytes [VAR_SLOTS];
    logic [BW-1:0]            r_gbytes;
    logic [ALL_BITS-1:0]      r_gregions;

    logic [VAR_BITS-1:0]      r_vidx;
    logic                     r_bad;
    logic                     r_zero;
    logic [A-1:0]             r_first;
    logic [A-1:0]             r_prod;
    logic [CNT_BITS-1:0]      r_n;
    logic [A-1:0]             r_last;
    logic                     r_hit;
    logic                     r_full;
    logic [A-1:0]             r_ns;
    logic [A-1:0]             r_ne;
    logic [BW-1:0]            r_old;
    logic [SLOT_BITS-1:0]     r_slot;
    logic [BW-1:0]            r_delta;

    logic                     r_oval;
    arc_pkg::t_status         r_status;
    logic [A-1:0]             r_rfirst;
    logic [A-1:0]             r_rlast;
    logic [BW-1:0]            r_ovbytes;
    logic [CNT_BITS-1:0]      r_ovregions;
    logic [BW-1:0]            r_oabytes;
    logic [ALL_BITS-1:0]      r_oaregions;

    logic                     w_accept;
    logic [VAR_BITS-1:0]      w_in_vidx;
    logic [CNT_BITS-1:0]      w_in_n;
    logic [A-1:0]             w_in_base;
    logic                     w_in_bad;
    logic [PROD_W-1:0]        w_prod_full;
    logic [MEM_ABITS-1:0]     w_raddr_a;
    logic [MEM_ABITS-1:0]     w_raddr_b;
    logic [ENTRY_W-1:0]       w_rd_a;
    logic [ENTRY_W-1:0]       w_rd_b;
    logic [A-1:0]             w_rs_a, w_re_a, w_rs_b, w_re_b;
    logic                     w_hit_a, w_hit_b;
    logic                     w_out_free;
    logic                     w_load;
    logic                     w_we;
    logic [MEM_ABITS-1:0]     w_waddr;
    logic [BW-1:0]            w_var_bytes;
    logic [BW-1:0]            w_all_bytes;

    arc_pkg::t_status         w_status;
    logic [A-1:0]             w_rfirst;
    logic [A-1:0]             w_rlast;
    logic [BW-1:0]            w_vb;
    logic [CNT_BITS-1:0]      w_vr;
    logic [BW-1:0]            w_ab;
    logic [ALL_BITS-1:0]      w_ar;

    // intake and memory read issue
    assign o_stall   = (r_state != S_IDLE);
    assign w_accept  = i_valid && (r_state == S_IDLE);
    assign w_in_vidx = i_var_index[VAR_BITS-1:0];
    assign w_in_n    = r_count[w_in_vidx];
    assign w_in_base = (i_var_index < arc_pkg::IDX_W'(arc_pkg::NUM_BASE_REGS)) ?
                       i_cfg.base[i_var_index[arc_pkg::BASE_IDX_W-1:0]] : '0;
    assign w_in_bad  = ({1'b0, i_var_index} >= NV_LIMIT) ||
                       (i_var_index >= arc_pkg::IDX_W'(i_cfg.num_vars));
    assign w_prod_full = i_elem_count * i_elem_bytes;
    assign w_raddr_a = {w_in_vidx, SLOT_BITS'(w_in_n - CNT_BITS'(1))};
    assign w_raddr_b = {w_in_vidx, SLOT_BITS'(w_in_n - CNT_BITS'(2))};

    // two copies of the region store give both window reads in the same cycle
    arc_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MEM_DEPTH)
    ) u_ram_a (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata ({r_ns, r_ne}),
        .i_re    (w_accept),
        .i_raddr (w_raddr_a),
        .o_rdata (w_rd_a)
    );

    arc_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MEM_DEPTH)
    ) u_ram_b (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata ({r_ns, r_ne}),
        .i_re    (w_accept),
        .i_raddr (w_raddr_b),
        .o_rdata (w_rd_b)
    );

    // window compare, newest region first
    assign w_rs_a  = w_rd_a[ENTRY_W-1:A];
    assign w_re_a  = w_rd_a[A-1:0];
    assign w_rs_b  = w_rd_b[ENTRY_W-1:A];
    assign w_re_b  = w_rd_b[A-1:0];
    assign w_hit_a = (r_n != '0) && hit_test(r_first, r_last, w_rs_a, w_re_a);
    assign w_hit_b = (r_n > CNT_BITS'(1)) && hit_test(r_first, r_last, w_rs_b, w_re_b);

    // write back and totals
    assign w_out_free  = !r_oval || !i_stall;
    assign w_load      = (r_state == S_WRITE) && w_out_free;
    assign w_we        = w_load && !r_bad && !r_zero && (r_hit || !r_full);
    assign w_waddr     = {r_vidx, r_slot};
    assign w_var_bytes = r_vbytes[r_vidx] + r_delta;
    assign w_all_bytes = r_gbytes + r_delta;

    always_comb begin
        w_status = arc_pkg::ST_NEW;
        w_rfirst = r_ns;
        w_rlast  = r_ne;
        w_vb     = w_var_bytes;
        w_vr     = r_n + CNT_BITS'(1);
        w_ab     = w_all_bytes;
        w_ar     = r_gregions + ALL_BITS'(1);
        if (r_bad) begin
            w_status = arc_pkg::ST_BAD_INDEX;
            w_rfirst = '0;
            w_rlast  = '0;
            w_vb     = '0;
            w_vr     = '0;
            w_ab     = r_gbytes;
            w_ar     = r_gregions;
        end else if (r_zero) begin
            w_status = arc_pkg::ST_ZERO_COUNT;
            w_rfirst = '0;
            w_rlast  = '0;
            w_vb     = r_vbytes[r_vidx];
            w_vr     = r_n;
            w_ab     = r_gbytes;
            w_ar     = r_gregions;
        end else if (r_hit) begin
            w_status = arc_pkg::ST_MERGED;
            w_vr     = r_n;
            w_ar     = r_gregions;
        end else if (r_full) begin
            w_status = arc_pkg::ST_FULL;
            w_vb     = r_vbytes[r_vidx];
            w_vr     = r_n;
            w_ab     = r_gbytes;
            w_ar     = r_gregions;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_LAST;
                end
            end
            S_LAST: begin
                n_state = S_MERGE;
            end
            S_MERGE: begin
                n_state = S_SPAN;
            end
            S_SPAN: begin
                n_state = S_WRITE;
            end
            S_WRITE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_oval     <= 1'b0;
            r_gbytes   <= '0;
            r_gregions <= '0;
            for (int v = 0; v < VAR_SLOTS; v++) begin
                r_count[v]  <= '0;
                r_vbytes[v] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (w_load) begin
                r_oval <= 1'b1;
            end else if (!i_stall) begin
                r_oval <= 1'b0;
            end
            if (w_we) begin
                r_vbytes[r_vidx] <= w_var_bytes;
                r_gbytes         <= w_all_bytes;
                if (!r_hit) begin
                    r_count[r_vidx] <= r_n + CNT_BITS'(1);
                    r_gregions      <= r_gregions + ALL_BITS'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_vidx  <= w_in_vidx;
            r_bad   <= w_in_bad;
            r_zero  <= (i_elem_count == '0);
            r_first <= i_start_address - w_in_base;
            r_prod  <= A'(w_prod_full);
            r_n     <= w_in_n;
        end
        if (r_state == S_LAST) begin
            r_last <= r_first + r_prod - A'(1);
        end
        if (r_state == S_MERGE) begin
            r_full <= (r_n >= MAX_CNT);
            r_hit  <= w_hit_a || w_hit_b;
            if (w_hit_a) begin
                r_ns   <= (r_first < w_rs_a) ? r_first : w_rs_a;
                r_ne   <= (r_last > w_re_a) ? r_last : w_re_a;
                r_old  <= span_size(w_rs_a, w_re_a);
                r_slot <= SLOT_BITS'(r_n - CNT_BITS'(1));
            end else if (w_hit_b) begin
                r_ns   <= (r_first < w_rs_b) ? r_first : w_rs_b;
                r_ne   <= (r_last > w_re_b) ? r_last : w_re_b;
                r_old  <= span_size(w_rs_b, w_re_b);
                r_slot <= SLOT_BITS'(r_n - CNT_BITS'(2));
            end else begin
                r_ns   <= r_first;
                r_ne   <= r_last;
                r_old  <= '0;
                r_slot <= SLOT_BITS'(r_n);
            end
        end
        if (r_state == S_SPAN) begin
            r_delta <= span_size(r_ns, r_ne) - r_old;
        end
        if (w_load) begin
            r_status    <= w_status;
            r_rfirst    <= w_rfirst;
            r_rlast     <= w_rlast;
            r_ovbytes   <= w_vb;
            r_ovregions <= w_vr;
            r_oabytes   <= w_ab;
            r_oaregions <= w_ar;
        end
    end

    assign o_valid        = r_oval;
    assign o_status       = r_status;
    assign o_region_first = r_rfirst;
    assign o_region_last  = r_rlast;
    assign o_var_bytes    = r_ovbytes;
    assign o_var_regions  = r_ovregions;
    assign o_all_bytes    = r_oabytes;
    assign o_all_regions  = r_oaregions;

    `ASSERT_PROP(a_accept_starts, i_clk, i_rst_n, (i_valid && !o_stall) |=> (r_state == S_LAST))
    `ASSERT_NEVER(a_count_cap, i_clk, i_rst_n, (r_state == S_MERGE) && !r_bad && (r_n > MAX_CNT))
    `ASSERT_PROP(a_merge_covers, i_clk, i_rst_n, (w_we && r_hit) |-> ((r_ns <= r_first) && (r_ne >= r_last)))
    `ASSERT_PROP(a_append_counts, i_clk, i_rst_n, (w_we && !r_hit) |=> (r_gregions == ($past(r_gregions) + ALL_BITS'(1))))

endmodule

// ===== rtl/address_range_coalescer_top.sv =====
// a word is taken in S_IDLE and steps through S_LAST, S_MERGE, S_SPAN and S_WRITE;
// its result is registered on leaving S_WRITE, which waits while the output is stalled;
// a new word is taken only once the read, compare, span and write-back of the last is done
// reset: synchronous active low; clears state, config, counts and totals; not region memory
// depends on arc_pkg, arc_cfg, arc_core (with arc_ram)
module address_range_coalescer_top #(
    parameter int NUM_VARS    = arc_pkg::DEF_NUM_VARS,
    parameter int MAX_REGIONS = arc_pkg::DEF_MAX_REGIONS
) (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  logic                                          psel,
    input  logic                                          penable,
    input  logic                                          pwrite,
    input  logic [arc_pkg::CFG_ADDR_W-1:0]                paddr,
    input  logic [arc_pkg::CFG_DATA_W-1:0]                pwdata,
    output logic [arc_pkg::CFG_DATA_W-1:0]                prdata,
    output logic                                          pready,
    input  logic                                          i_valid,
    output logic                                          o_stall,
    input  logic [arc_pkg::IDX_W-1:0]                     i_var_index,
    input  logic [arc_pkg::ADDR_BITS-1:0]                 i_start_address,
    input  logic [arc_pkg::COUNT_W-1:0]                   i_elem_count,
    input  logic [arc_pkg::ESIZE_W-1:0]                   i_elem_bytes,
    output logic                                          o_valid,
    input  logic                                          i_stall,
    output logic [arc_pkg::STATUS_W-1:0]                  o_status,
    output logic [arc_pkg::ADDR_BITS-1:0]                 o_region_first,
    output logic [arc_pkg::ADDR_BITS-1:0]                 o_region_last,
    output logic [arc_pkg::BYTES_W-1:0]                   o_var_bytes,
    output logic [$clog2(MAX_REGIONS+1)-1:0]              o_var_regions,
    output logic [arc_pkg::BYTES_W-1:0]                   o_all_bytes,
    output logic [$clog2(NUM_VARS*MAX_REGIONS+1)-1:0]     o_all_regions
);

    arc_pkg::t_cfg w_cfg;

    arc_cfg #(
        .NUM_VARS (NUM_VARS)
    ) u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    arc_core #(
        .NUM_VARS    (NUM_VARS),
        .MAX_REGIONS (MAX_REGIONS)
    ) u_core (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (w_cfg),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_var_index     (i_var_index),
        .i_start_address (i_start_address),
        .i_elem_count    (i_elem_count),
        .i_elem_bytes    (i_elem_bytes),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_status        (o_status),
        .o_region_first  (o_region_first),
        .o_region_last   (o_region_last),
        .o_var_bytes     (o_var_bytes),
        .o_var_regions   (o_var_regions),
        .o_all_bytes     (o_all_bytes),
        .o_all_regions   (o_all_regions)
    );

endmodule
